>>> hdl/aldsd_pkg.sv
`default_nettype none

package aldsd_pkg;

   // Sample averaging
   localparam int SAMPLES_AVERAGED = 4;
   localparam int AVG_COUNT = (SAMPLES_AVERAGED < 1) ? 1 :
                              (SAMPLES_AVERAGED > 4) ? 4 : SAMPLES_AVERAGED;
   localparam int SAMPLE_W = 10;
   localparam int SUM_W    = SAMPLE_W + 2;
   localparam int DUTY_W   = 8;
   localparam int NUM_W    = SAMPLE_W + DUTY_W;
   localparam int QUOT_W   = DUTY_W;

   // Divide by three: (sum * 2731) >> 13 is exact for every 12-bit sum
   localparam int DIV3_MUL   = 2731;
   localparam int DIV3_SHIFT = 13;
   localparam int DIV3_W     = SUM_W + 13;

   // Span divider layout
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

   // Request accepted to strobe: front (2), divider, readout (3)
   localparam int PIPE_LATENCY = 5 + DIV_STAGES;

   localparam logic [DUTY_W-1:0]   FULL_DUTY = 8'hFF;
   localparam logic [7:0]          SEG_BLANK = 8'hFF;
   localparam logic [SAMPLE_W-1:0] SHOWN_MAX = 10'd999;

   // Percent of an 8-bit duty: x / 255 == (x + (x >> 8) + 1) >> 8 for x below 65535
   localparam int PCT_SCALE = 100;

   // Digit split by reciprocal multiply, exact for the ranges used here
   localparam int DIV100_MUL   = 41;
   localparam int DIV100_SHIFT = 12;
   localparam int DIV10_MUL    = 205;
   localparam int DIV10_SHIFT  = 11;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHT       = 3'd0,
      CSR_DARK         = 3'd1,
      CSR_MIN_DUTY     = 3'd2,
      CSR_SHOW_PERCENT = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_first;
      logic [SAMPLE_W-1:0] sample_second;
      logic [SAMPLE_W-1:0] sample_third;
      logic [SAMPLE_W-1:0] sample_fourth;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]   duty;
      logic [SAMPLE_W-1:0] shown_value;
      logic [7:0]          segments_hundreds;
      logic [7:0]          segments_tens;
      logic [7:0]          segments_ones;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] bright_threshold;
      logic [SAMPLE_W-1:0] dark_threshold;
      logic [DUTY_W-1:0]   minimum_duty;
      logic                show_percent;
   } cfg_type;

   // Travels alongside the arithmetic through the front and divider stages
   typedef struct packed {
      logic                valid;
      logic                at_bright;
      logic                at_dark;
      logic [SAMPLE_W-1:0] avg;
   } side_type;

   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

>>> hdl/aldsd_csr.sv
`default_nettype none

module aldsd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [aldsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [aldsd_pkg::CSR_DATA_W-1:0]     csr_data,
   output aldsd_pkg::cfg_type                        cfg
);

   aldsd_pkg::cfg_type cfg_ff;
   aldsd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            aldsd_pkg::CSR_BRIGHT:
               cfg_in.bright_threshold = csr_data[aldsd_pkg::SAMPLE_W-1:0];
            aldsd_pkg::CSR_DARK:
               cfg_in.dark_threshold = csr_data[aldsd_pkg::SAMPLE_W-1:0];
            aldsd_pkg::CSR_MIN_DUTY:
               cfg_in.minimum_duty = csr_data[aldsd_pkg::DUTY_W-1:0];
            aldsd_pkg::CSR_SHOW_PERCENT:
               cfg_in.show_percent = csr_data[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_threshold <= 10'd200;
         cfg_ff.dark_threshold   <= 10'd450;
         cfg_ff.minimum_duty     <= 8'd20;
         cfg_ff.show_percent     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/aldsd_front.sv
`default_nettype none

module aldsd_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire aldsd_pkg::req_type                  req,
   input  wire aldsd_pkg::cfg_type                  cfg,
   output aldsd_pkg::side_type                      side_out,
   output logic [aldsd_pkg::NUM_W-1:0]              num_out,
   output logic [aldsd_pkg::SAMPLE_W-1:0]           span_out
);

   localparam int SW = aldsd_pkg::SAMPLE_W;

   aldsd_pkg::side_type            s1_side_in, s1_side_ff;
   logic [SW-1:0]                  s1_diff_in, s1_diff_ff;
   logic [aldsd_pkg::DUTY_W-1:0]   s1_factor_in, s1_factor_ff;
   logic [SW-1:0]                  s1_span_in, s1_span_ff;

   aldsd_pkg::side_type            s2_side_ff;
   logic [aldsd_pkg::NUM_W-1:0]    s2_num_in, s2_num_ff;
   logic [SW-1:0]                  s2_span_ff;

   logic [SW-1:0]                  smp [4];
   logic [aldsd_pkg::SUM_W-1:0]    sum;
   logic [aldsd_pkg::DIV3_W-1:0]   third;
   logic [SW-1:0]                  avg;

   // Stage 1: sum, average, threshold tests, distance, duty factor and span
   always_comb begin
      smp[0] = req.sample_first;
      smp[1] = req.sample_second;
      smp[2] = req.sample_third;
      smp[3] = req.sample_fourth;
      sum = '0;
      for (int i = 0; i < aldsd_pkg::AVG_COUNT; i++) begin
         sum = sum + aldsd_pkg::SUM_W'(smp[i]);
      end
      third = aldsd_pkg::DIV3_W'(sum) * aldsd_pkg::DIV3_W'(aldsd_pkg::DIV3_MUL);
      case (aldsd_pkg::AVG_COUNT)
         1:       avg = sum[SW-1:0];
         2:       avg = sum[SW:1];
         3:       avg = third[aldsd_pkg::DIV3_SHIFT +: SW];
         default: avg = sum[SW+1:2];
      endcase

      s1_side_in.valid     = accept;
      s1_side_in.at_bright = (avg <= cfg.bright_threshold);
      s1_side_in.at_dark   = (avg >= cfg.dark_threshold);
      s1_side_in.avg       = avg;
      s1_diff_in   = avg - cfg.bright_threshold;
      s1_factor_in = aldsd_pkg::FULL_DUTY - cfg.minimum_duty;
      s1_span_in   = cfg.dark_threshold - cfg.bright_threshold;
   end

   // Stage 2: scale the distance past the bright threshold
   assign s2_num_in = aldsd_pkg::NUM_W'(s1_diff_ff) * aldsd_pkg::NUM_W'(s1_factor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
         s2_side_ff <= '0;
      end else begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
      end
      s1_diff_ff   <= s1_diff_in;
      s1_factor_ff <= s1_factor_in;
      s1_span_ff   <= s1_span_in;
      s2_num_ff    <= s2_num_in;
      s2_span_ff   <= s1_span_ff;
   end

   assign side_out = s2_side_ff;
   assign num_out  = s2_num_ff;
   assign span_out = s2_span_ff;

endmodule

`default_nettype wire

>>> hdl/aldsd_div.sv
`default_nettype none

module aldsd_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire aldsd_pkg::side_type                 side_in,
   input  wire logic [aldsd_pkg::NUM_W-1:0]         num_in,
   input  wire logic [aldsd_pkg::SAMPLE_W-1:0]      span_in,
   output aldsd_pkg::side_type                      side_out,
   output logic [aldsd_pkg::QUOT_W-1:0]             quot_out
);

   localparam int SW = aldsd_pkg::SAMPLE_W;
   localparam int QW = aldsd_pkg::QUOT_W;

   typedef struct packed {
      aldsd_pkg::side_type side;
      logic [SW-1:0]       rem;
      logic [QW-1:0]       rest;
      logic [QW-1:0]       quot;
      logic [SW-1:0]       span;
   } div_stage_type;

   div_stage_type entry;
   div_stage_type stage_in [aldsd_pkg::DIV_STAGES];
   div_stage_type stage_ff [aldsd_pkg::DIV_STAGES];

   // The quotient fits in QW bits whenever it is used, so the top bits of the
   // numerator start out as a partial remainder already below the span.
   always_comb begin
      entry.side = side_in;
      entry.rem  = num_in[aldsd_pkg::NUM_W-1:QW];
      entry.rest = num_in[QW-1:0];
      entry.quot = '0;
      entry.span = span_in;
   end

   for (genvar s = 0; s < aldsd_pkg::DIV_STAGES; s++) begin : g_stage
      div_stage_type prev;

      if (s == 0) begin : g_first
         assign prev = entry;
      end else begin : g_next
         assign prev = stage_ff[s-1];
      end

      always_comb begin
         div_stage_type work;
         logic [SW:0]   wide;
         logic          ge;
         work = prev;
         for (int b = 0; b < aldsd_pkg::DIV_BITS_PER_STAGE; b++) begin
            wide = {work.rem, work.rest[QW-1]};
            work.rest = {work.rest[QW-2:0], 1'b0};
            ge = (wide >= {1'b0, work.span});
            if (ge) begin
               wide = wide - {1'b0, work.span};
            end
            work.rem  = wide[SW-1:0];
            work.quot = {work.quot[QW-2:0], ge};
         end
         stage_in[s] = work;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s] <= '0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign side_out = stage_ff[aldsd_pkg::DIV_STAGES-1].side;
   assign quot_out = stage_ff[aldsd_pkg::DIV_STAGES-1].quot;

endmodule

`default_nettype wire

>>> hdl/aldsd_readout.sv
`default_nettype none

module aldsd_readout (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire aldsd_pkg::side_type                 side_in,
   input  wire logic [aldsd_pkg::QUOT_W-1:0]        quot_in,
   input  wire aldsd_pkg::cfg_type                  cfg,
   output logic                                     rsp_valid,
   output aldsd_pkg::rsp_type                       rsp_payload
);

   localparam int SW = aldsd_pkg::SAMPLE_W;
   localparam int DW = aldsd_pkg::DUTY_W;
   localparam int PW = 16;

   // Stage A: duty and the value to show
   logic            a_valid_ff;
   logic [DW-1:0]   a_duty_in, a_duty_ff;
   logic [SW-1:0]   a_val_in, a_val_ff;
   logic [PW-1:0]   pct_prod;
   logic [PW-1:0]   pct_sum;

   // Stage B: hundreds digit
   logic            b_valid_ff;
   logic [DW-1:0]   b_duty_ff;
   logic [SW-1:0]   b_val_ff;
   logic [3:0]      b_hund_in, b_hund_ff;
   logic [6:0]      b_rem_in, b_rem_ff;
   logic [PW-1:0]   hund_prod;

   // Stage C: tens and ones, segment decode
   logic                 out_valid_ff;
   aldsd_pkg::rsp_type   out_in, out_ff;
   logic [PW-1:0]        tens_prod;
   logic [3:0]           tens;
   logic [3:0]           ones;

   always_comb begin
      if (side_in.at_bright) begin
         a_duty_in = aldsd_pkg::FULL_DUTY;
      end else if (side_in.at_dark) begin
         a_duty_in = cfg.minimum_duty;
      end else begin
         a_duty_in = aldsd_pkg::FULL_DUTY - quot_in;
      end
      pct_prod = PW'(a_duty_in) * PW'(aldsd_pkg::PCT_SCALE);
      pct_sum  = pct_prod + (pct_prod >> 8) + PW'(1);
      if (cfg.show_percent) begin
         a_val_in = SW'(pct_sum[PW-1:8]);
      end else if (side_in.avg > aldsd_pkg::SHOWN_MAX) begin
         a_val_in = aldsd_pkg::SHOWN_MAX;
      end else begin
         a_val_in = side_in.avg;
      end
   end

   always_comb begin
      hund_prod = PW'(a_val_ff) * PW'(aldsd_pkg::DIV100_MUL);
      b_hund_in = hund_prod[aldsd_pkg::DIV100_SHIFT +: 4];
      b_rem_in  = 7'(a_val_ff - SW'(SW'(b_hund_in) * SW'(100)));
   end

   always_comb begin
      tens_prod = PW'(b_rem_ff) * PW'(aldsd_pkg::DIV10_MUL);
      tens      = tens_prod[aldsd_pkg::DIV10_SHIFT +: 4];
      ones      = 4'(b_rem_ff - 7'(7'(tens) * 7'(10)));

      out_in.duty              = b_duty_ff;
      out_in.shown_value       = b_val_ff;
      out_in.segments_hundreds = (b_hund_ff == 4'd0) ? aldsd_pkg::SEG_BLANK
                                                     : aldsd_pkg::seg_of(b_hund_ff);
      out_in.segments_tens     = (b_hund_ff == 4'd0 && tens == 4'd0)
                                 ? aldsd_pkg::SEG_BLANK : aldsd_pkg::seg_of(tens);
      out_in.segments_ones     = aldsd_pkg::seg_of(ones);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= side_in.valid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
      a_duty_ff <= a_duty_in;
      a_val_ff  <= a_val_in;
      b_duty_ff <= a_duty_ff;
      b_val_ff  <= a_val_ff;
      b_hund_ff <= b_hund_in;
      b_rem_ff  <= b_rem_in;
      out_ff    <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

>>> hdl/ambient_light_dimmer_segment_display.sv
//  channel    ports                                    handshake
//  ---------  ---------------------------------------  -----------------------------
//  request    start, busy, req_payload                 start high, busy low
//  result     rsp_valid, rsp_payload                   rsp_valid strobe, one cycle
//  config     csr_valid, csr_ready, csr_index, csr_data csr_valid and csr_ready high
//
//  One sample set enters every cycle; busy never rises. Each result is registered
//  through two front stages (average, scaled distance), one divider stage per two
//  quotient bits (four), and three readout stages (duty and percent, hundreds split,
//  tens split and decode).
//  Synchronous reset clears the valid bits of every stage and loads the
//  register defaults; items in flight at reset are dropped.
//  The receiver cannot stall, so the pipeline advances on every clock.
`default_nettype none

module ambient_light_dimmer_segment_display (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire aldsd_pkg::req_type                  req_payload,
   output logic                                     rsp_valid,
   output aldsd_pkg::rsp_type                       rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [aldsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [aldsd_pkg::CSR_DATA_W-1:0]    csr_data
);

   aldsd_pkg::cfg_type                  cfg;
   aldsd_pkg::side_type                 front_side;
   logic [aldsd_pkg::NUM_W-1:0]         front_num;
   logic [aldsd_pkg::SAMPLE_W-1:0]      front_span;
   aldsd_pkg::side_type                 div_side;
   logic [aldsd_pkg::QUOT_W-1:0]        div_quot;
   logic                                accept;

   // Fully pipelined: a new transaction is taken on every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Threshold, minimum duty and display mode registers, read directly by the stages.
   // The user must change them only while no transaction is in flight (not enforced).
   aldsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Average the samples, test them against both thresholds and form
   // (avg - bright) * (255 - minimum) for the linear region
   aldsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .cfg      (cfg),
      .side_out (front_side),
      .num_out  (front_num),
      .span_out (front_span)
   );

   // Restoring divide by the threshold span, two quotient bits per stage.
   // Outside the linear region the quotient is ignored downstream.
   aldsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .side_in  (front_side),
      .num_in   (front_num),
      .span_in  (front_span),
      .side_out (div_side),
      .quot_out (div_quot)
   );

   // Pick the duty, form the shown value and decode three digits with
   // leading zero blanking
   aldsd_readout u_readout (
      .clock       (clock),
      .reset       (reset),
      .side_in     (div_side),
      .quot_in     (div_quot),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   // Every result traces back to an accepted transaction
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, aldsd_pkg::PIPE_LATENCY))
      else $error("result strobe without a matching request");

   // The display never shows more than three digits
   a_shown_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.shown_value <= aldsd_pkg::SHOWN_MAX)
      else $error("shown value above saturation limit");

   // Single digit values blank both upper digits and show a real ones digit
   a_leading_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.shown_value < 10'd10) |->
         (rsp_payload.segments_hundreds == aldsd_pkg::SEG_BLANK &&
          rsp_payload.segments_tens == aldsd_pkg::SEG_BLANK &&
          rsp_payload.segments_ones != aldsd_pkg::SEG_BLANK))
      else $error("leading zero blanking broken");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import aldsd_pkg::*;

   // Run limits, counted in clock cycles
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_LIMIT = 4 * PIPE_LATENCY + 50;

   // Register values loaded by reset
   localparam logic [SAMPLE_W-1:0] DEFAULT_BRIGHT = 10'd200;
   localparam logic [SAMPLE_W-1:0] DEFAULT_DARK   = 10'd450;
   localparam logic [DUTY_W-1:0]   DEFAULT_MIN    = 8'd20;
   localparam logic                DEFAULT_SHOW   = 1'b1;

   // Index past the end of the register list; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam int unsigned PERCENT_FULL = 100;
   localparam int unsigned DISPLAY_MAX  = 999;

   // Active-low segment codes, digits 0 to 9
   localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Register contents as the block should hold them, updated on each write transaction
   cfg_type light_setting;

   rsp_type expected_readouts[$];
   rsp_type oldest_readout;

   int mismatches = 0;
   int accepted_sets = 0;
   int checked_readouts = 0;
   int settings_applied = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;

   ambient_light_dimmer_segment_display uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bail out if the run hangs anywhere
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ambient_light_dimmer_segment_display: mismatch");
         $finish;
      end
   end

   function automatic logic [7:0] segment_code(input int unsigned digit);
      return (digit < 10) ? DIGIT_SEGMENTS[digit] : SEG_BLANK;
   endfunction

   // Expected readout for one sample set under the current register contents
   function automatic rsp_type predict_readout(input req_type set);
      logic [SAMPLE_W-1:0] samples [4];
      int unsigned total, average, level, value;
      rsp_type readout;
      samples = '{set.sample_first, set.sample_second, set.sample_third, set.sample_fourth};
      total = 0;
      for (int i = 0; i < AVG_COUNT; i++)
         total += samples[i];
      average = total / AVG_COUNT;

      // Bright test comes first, so crossed thresholds never reach the division
      if (average <= light_setting.bright_threshold)
         level = 255;
      else if (average >= light_setting.dark_threshold)
         level = light_setting.minimum_duty;
      else
         level = 255 - ((average - light_setting.bright_threshold)
                        * (255 - light_setting.minimum_duty))
                       / (light_setting.dark_threshold - light_setting.bright_threshold);

      value = light_setting.show_percent ? (level * PERCENT_FULL) / 255 : average;
      if (value > DISPLAY_MAX)
         value = DISPLAY_MAX;

      readout.duty              = level[DUTY_W-1:0];
      readout.shown_value       = value[SAMPLE_W-1:0];
      // Blank leading zeros; the ones digit always shows
      readout.segments_hundreds = (value < 100) ? SEG_BLANK : segment_code(value / 100);
      readout.segments_tens     = (value < 10) ? SEG_BLANK : segment_code((value / 10) % 10);
      readout.segments_ones     = segment_code(value % 10);
      return readout;
   endfunction

   task automatic report_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d (0x%0h), actual %0d (0x%0h)", field, want, want, got, got);
         mismatches++;
      end
   endtask

   // Watch all three channels at each edge. Check results against the oldest pending
   // prediction, track register writes, and queue a prediction per accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         light_setting.bright_threshold = DEFAULT_BRIGHT;
         light_setting.dark_threshold   = DEFAULT_DARK;
         light_setting.minimum_duty     = DEFAULT_MIN;
         light_setting.show_percent     = DEFAULT_SHOW;
      end else begin
         if (rsp_valid) begin
            if (expected_readouts.size() == 0) begin
               $error("readout strobed with no pending transaction");
               mismatches++;
            end else begin
               oldest_readout = expected_readouts.pop_front();
               report_field("duty", oldest_readout.duty, rsp_payload.duty);
               report_field("shown_value", oldest_readout.shown_value,
                            rsp_payload.shown_value);
               report_field("segments_hundreds", oldest_readout.segments_hundreds,
                            rsp_payload.segments_hundreds);
               report_field("segments_tens", oldest_readout.segments_tens,
                            rsp_payload.segments_tens);
               report_field("segments_ones", oldest_readout.segments_ones,
                            rsp_payload.segments_ones);
               checked_readouts++;
            end
         end
         if (csr_valid && csr_ready) begin
            // Mask each value to its register width; drop unknown indexes
            case (csr_index)
               CSR_BRIGHT:       light_setting.bright_threshold = csr_data[SAMPLE_W-1:0];
               CSR_DARK:         light_setting.dark_threshold   = csr_data[SAMPLE_W-1:0];
               CSR_MIN_DUTY:     light_setting.minimum_duty     = csr_data[DUTY_W-1:0];
               CSR_SHOW_PERCENT: light_setting.show_percent     = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_readouts.push_back(predict_readout(req_payload));
            accepted_sets++;
         end
      end
   end

   // Hold one sample set on the request port until accepted. Keep start high on
   // return unless an idle gap is drawn, so back-to-back sets need no second drive.
   task automatic send_sample_set(input req_type set);
      start <= 1'b1;
      req_payload <= set;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Drop start and wait for every pending readout, then give the pipeline its latency
   task automatic settle_pipeline();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_readouts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_readouts.size() != 0) begin
         $error("%0d readouts never arrived", expected_readouts.size());
         mismatches += expected_readouts.size();
         expected_readouts.delete();
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Load all four registers once the pipeline is empty
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] bright, input logic [CSR_DATA_W-1:0] dark,
                                input logic [CSR_DATA_W-1:0] min_level,
                                input logic [CSR_DATA_W-1:0] show);
      settle_pipeline();
      write_register(CSR_BRIGHT, bright);
      write_register(CSR_DARK, dark);
      write_register(CSR_MIN_DUTY, min_level);
      write_register(CSR_SHOW_PERCENT, show);
      settings_applied++;
   endtask

   function automatic req_type uniform_set(input logic [SAMPLE_W-1:0] level);
      return '{level, level, level, level};
   endfunction

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int level);
      if (level < 0)
         return '0;
      if (level > 1023)
         return 10'd1023;
      return level[SAMPLE_W-1:0];
   endfunction

   // Most sets cluster inside the ramp between the thresholds; the rest are
   // fully random or pinned to the threshold and range ends.
   function automatic req_type random_sample_set();
      int center;
      int mode;
      logic [SAMPLE_W-1:0] picks [4];
      req_type set;
      mode = $urandom_range(9);
      if (mode <= 5) begin
         center = $urandom_range(light_setting.bright_threshold, light_setting.dark_threshold);
         set.sample_first  = clamp_sample(center + int'($urandom_range(6)) - 3);
         set.sample_second = clamp_sample(center + int'($urandom_range(6)) - 3);
         set.sample_third  = clamp_sample(center + int'($urandom_range(6)) - 3);
         set.sample_fourth = clamp_sample(center + int'($urandom_range(6)) - 3);
      end else if (mode <= 8) begin
         set.sample_first  = SAMPLE_W'($urandom);
         set.sample_second = SAMPLE_W'($urandom);
         set.sample_third  = SAMPLE_W'($urandom);
         set.sample_fourth = SAMPLE_W'($urandom);
      end else begin
         picks = '{10'd0, 10'd1023, light_setting.bright_threshold,
                   light_setting.dark_threshold};
         set.sample_first  = picks[$urandom_range(3)];
         set.sample_second = picks[$urandom_range(3)];
         set.sample_third  = picks[$urandom_range(3)];
         set.sample_fourth = picks[$urandom_range(3)];
      end
      return set;
   endfunction

   // Reset values: both threshold edges, the ends of the range, truncating average
   task automatic test_default_mapping();
      sender_idle_pct = 0;
      send_sample_set(uniform_set(10'd0));
      send_sample_set(uniform_set(10'd1023));
      send_sample_set(uniform_set(DEFAULT_BRIGHT));
      send_sample_set(uniform_set(DEFAULT_BRIGHT + 10'd1));
      send_sample_set(uniform_set(DEFAULT_DARK - 10'd1));
      send_sample_set(uniform_set(DEFAULT_DARK));
      send_sample_set('{10'd3, 10'd0, 10'd0, 10'd0});
      send_sample_set('{10'h2AA, 10'h155, 10'h2AA, 10'h155});
   endtask

   // Raw average on the display: blanking of leading zeros and saturation at 999
   task automatic test_raw_readout();
      apply_setting(DEFAULT_BRIGHT, DEFAULT_DARK, DEFAULT_MIN, 10'd0);
      send_sample_set(uniform_set(10'd0));
      send_sample_set(uniform_set(10'd7));
      send_sample_set(uniform_set(10'd10));
      send_sample_set(uniform_set(10'd99));
      send_sample_set(uniform_set(10'd100));
      send_sample_set(uniform_set(10'd999));
      send_sample_set('{10'd1023, 10'd1023, 10'd1023, 10'd1022});
   endtask

   // Bright above dark, then equal thresholds: no ramp at all
   task automatic test_crossed_thresholds();
      apply_setting(10'd600, 10'd300, 10'd77, 10'd1);
      send_sample_set(uniform_set(10'd600));
      send_sample_set(uniform_set(10'd601));
      send_sample_set(uniform_set(10'd400));
      apply_setting(10'd512, 10'd512, 10'd140, 10'd0);
      send_sample_set(uniform_set(10'd512));
      send_sample_set(uniform_set(10'd513));
   endtask

   // Widest ramp, masking of wide writes, unknown index, full-range crossed thresholds
   task automatic test_register_extremes();
      apply_setting(10'd0, 10'd1023, 10'd0, 10'd1);
      send_sample_set(uniform_set(10'd1));
      send_sample_set(uniform_set(10'd1022));
      settle_pipeline();
      write_register(CSR_UNUSED_INDEX, 10'h3FF);
      send_sample_set(uniform_set(10'd511));
      // Upper data bits set: minimum duty masks to 255, show_percent to 0
      apply_setting(10'd1023, 10'd0, 10'h3FF, 10'h3FE);
      send_sample_set(uniform_set(10'd1023));
      send_sample_set(uniform_set(10'd0));
   endtask

   // Random register settings per batch, random sets under one idling pattern
   task automatic test_random_traffic(input int idle_pct, input int batches, input int per_batch);
      logic [CSR_DATA_W-1:0] bright, dark;
      for (int b = 0; b < batches; b++) begin
         bright = CSR_DATA_W'($urandom_range(900));
         dark   = CSR_DATA_W'(bright + $urandom_range(1, 1023 - bright));
         // Now and then swap them to exercise crossed thresholds
         if ($urandom_range(5) == 0)
            apply_setting(dark, bright, CSR_DATA_W'($urandom_range(1023)),
                          CSR_DATA_W'($urandom_range(1023)));
         else
            apply_setting(bright, dark, CSR_DATA_W'($urandom_range(1023)),
                          CSR_DATA_W'($urandom_range(1023)));
         sender_idle_pct = idle_pct;
         for (int i = 0; i < per_batch; i++)
            send_sample_set(random_sample_set());
         sender_idle_pct = 0;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_mapping();
      test_raw_readout();
      test_crossed_thresholds();
      test_register_extremes();
      test_random_traffic(0, 3, 61);
      test_random_traffic(76, 3, 61);
      test_random_traffic(9, 3, 61);

      settle_pipeline();
      $display("Ran %0d sample sets (%0d readouts checked) over %0d register settings,",
               accepted_sets, checked_readouts, settings_applied);
      $display("with the sender idling at 0, 9 and 76 percent of cycles.");
      if (mismatches == 0) begin
         $display("ambient_light_dimmer_segment_display: match");
      end else begin
         $display("ambient_light_dimmer_segment_display: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/aldsd_pkg.sv
hdl/aldsd_csr.sv
hdl/aldsd_front.sv
hdl/aldsd_div.sv
hdl/aldsd_readout.sv
hdl/ambient_light_dimmer_segment_display.sv
tb/tb.sv
